// File: src/sapq_pkg.sv
// ---------------------------------------------------------------------------
// sapq_pkg: shared types and constants for the sorted array priority queue
// Holds the beat structs of both channels, the status and operation codes,
// and the control bundle between the controller and the datapath.
// ---------------------------------------------------------------------------
package sapq_pkg;

  // Fixed widths of the channel fields.
  localparam int VALUE_WIDTH = 32;
  localparam int OCC_WIDTH   = 5;
  localparam int CAP_WIDTH   = 5;

  // Default storage depth and reset capacity.
  localparam int              DEPTH_DEFAULT = 16;
  localparam logic [CAP_WIDTH-1:0] CAP_RESET = 5'd16;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_PUSHED    = 2'd0,
    ST_POPPED    = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_t;

  // Input command codes.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  // Input beat.
  typedef struct packed {
    logic                          command;
    logic signed [VALUE_WIDTH-1:0] value;
  } in_item_t;

  // Result beat.
  typedef struct packed {
    status_t                       status;
    logic signed [VALUE_WIDTH-1:0] popped_value;
    logic [OCC_WIDTH-1:0]          occupancy;
  } out_item_t;

  // Controller states.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Datapath operations.
  typedef enum logic [2:0] {
    OP_NONE      = 3'd0,
    OP_PUSH      = 3'd1,
    OP_POP       = 3'd2,
    OP_OVERFLOW  = 3'd3,
    OP_UNDERFLOW = 3'd4
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    op_t  op;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_delete;
    logic full;
    logic empty;
  } ctl_sts_t;

endpackage

// File: src/sapq_ctrl.sv
// ---------------------------------------------------------------------------
// sapq_ctrl: controller for the sorted array priority queue
// Accepts an input beat, decides the operation from the datapath status and
// hands the result to the output register when it is free.
// ---------------------------------------------------------------------------
module sapq_ctrl
  import sapq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output ctl_cmd_t cmd,
  input  ctl_sts_t sts
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // State and output valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign slot_free = !out_valid_r || out_ready;

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd.latch     = 1'b0;
    cmd.op        = OP_NONE;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          if (sts.is_delete) begin
            cmd.op = sts.empty ? OP_UNDERFLOW : OP_POP;
          end else begin
            cmd.op = sts.full ? OP_OVERFLOW : OP_PUSH;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// File: src/sapq_datapath.sv
// ---------------------------------------------------------------------------
// sapq_datapath: sorted entry row, count, capacity and result register
// Each cell compares the new value with its own entry and its neighbor's,
// so an insert or a delete shifts the whole row in parallel.
// ---------------------------------------------------------------------------
module sapq_datapath
  import sapq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  in_item_t             in_data,
  input  logic                 cfg_we,
  input  logic [CAP_WIDTH-1:0] cfg_data,
  input  ctl_cmd_t             cmd,
  output ctl_sts_t             sts,
  output out_item_t            out_data
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > CAP_WIDTH) ? CW : CAP_WIDTH;
  localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

  logic                          cmd_r;
  logic signed [VALUE_WIDTH-1:0] val_r;
  logic [CAP_WIDTH-1:0]          cap_r;
  logic [CW-1:0]                 count_r;
  logic signed [VALUE_WIDTH-1:0] entries_r [DEPTH];
  logic signed [VALUE_WIDTH-1:0] ins_nxt   [DEPTH];
  logic signed [VALUE_WIDTH-1:0] del_nxt   [DEPTH];
  logic [DEPTH-1:0]              ge;
  out_item_t                     out_r;
  logic [LW-1:0]                 cap_l, cnt_l, lim_l;

  // Control registers: capacity and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      count_r <= '0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
      case (cmd.op)
        OP_PUSH: count_r <= count_r + CW'(1);
        OP_POP:  count_r <= count_r - CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  // Latched input beat.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r <= in_data.command;
      val_r <= in_data.value;
    end
  end

  // Limit is the capacity capped at the depth.
  assign cap_l = LW'(cap_r);
  assign cnt_l = LW'(count_r);
  assign lim_l = (cap_l < DEPTH_L) ? cap_l : DEPTH_L;

  assign sts.is_delete = (cmd_r == CMD_DELETE);
  assign sts.full      = (cnt_l >= lim_l);
  assign sts.empty     = (count_r == '0);

  // Per-cell insert and delete next values.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    // An empty cell counts as lower than any new value.
    assign ge[i] = (CW'(i) >= count_r) || (val_r >= entries_r[i]);

    if (i == 0) begin : g_first
      assign ins_nxt[i] = ge[i] ? val_r : entries_r[i];
    end else begin : g_rest
      assign ins_nxt[i] = !ge[i] ? entries_r[i] :
                          (ge[i-1] ? entries_r[i-1] : val_r);
    end

    if (i == DEPTH - 1) begin : g_last
      assign del_nxt[i] = entries_r[i];
    end else begin : g_inner
      assign del_nxt[i] = entries_r[i+1];
    end

    always_ff @(posedge clk) begin
      case (cmd.op)
        OP_PUSH: entries_r[i] <= ins_nxt[i];
        OP_POP:  entries_r[i] <= del_nxt[i];
        default: entries_r[i] <= entries_r[i];
      endcase
    end
  end

  // Result register, loaded when the operation completes.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_PUSH: begin
        out_r.status       <= ST_PUSHED;
        out_r.popped_value <= '0;
        out_r.occupancy    <= OCC_WIDTH'(count_r + CW'(1));
      end
      OP_POP: begin
        out_r.status       <= ST_POPPED;
        out_r.popped_value <= entries_r[0];
        out_r.occupancy    <= OCC_WIDTH'(count_r - CW'(1));
      end
      OP_OVERFLOW: begin
        out_r.status       <= ST_OVERFLOW;
        out_r.popped_value <= '0;
        out_r.occupancy    <= OCC_WIDTH'(count_r);
      end
      OP_UNDERFLOW: begin
        out_r.status       <= ST_UNDERFLOW;
        out_r.popped_value <= '0;
        out_r.occupancy    <= OCC_WIDTH'(count_r);
      end
      default: begin
        out_r <= out_r;
      end
    endcase
  end

  assign out_data = out_r;

endmodule

// File: src/sorted_array_priority_queue_top.sv
// ---------------------------------------------------------------------------
// sorted_array_priority_queue_top: max-priority queue on a sorted entry row
//
//   channel | direction | handshake         | beat
//   in_     | input     | in_valid/ready    | in_item_t  (command, value)
//   out_    | output    | out_valid/ready   | out_item_t (status, value, occ)
//   cfg_    | input     | cfg_we            | capacity, 5 bits
//
// Each item is accepted in the idle state; in the execute state the row
// of cells compares and shifts and the result register loads.
// The next beat is accepted while a result waits in the output register;
// a stalled output holds the item in execute until the register frees.
// Reset (synchronous, rst_n low) empties the queue and sets capacity to 16.
// ---------------------------------------------------------------------------
module sorted_array_priority_queue_top
  import sapq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CAP_WIDTH-1:0] cfg_data
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // Controller.
  sapq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Datapath.
  sapq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for the sorted array priority queue
// A queue-fed driver presents insert and delete beats. A scoreboard model of
// the descending entry row predicts each result, and a monitor compares the
// results field by field. Capacity is rewritten between phases, and both
// channels stall at random.
// ---------------------------------------------------------------------------
module tb;
  import sapq_pkg::*;

  localparam int QDEPTH          = DEPTH_DEFAULT;
  localparam int ITEMS_PER_PHASE = 195;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int MAX_REPORTS     = 10;

  // Clock, reset and block ports.
  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CAP_WIDTH-1:0] cfg_data  = '0;

  // Beats waiting for the driver, and results waiting for the monitor.
  in_item_t  pending_items[$];
  out_item_t expected_results[$];

  // Scoreboard copy of the queue state and the capacity register.
  logic signed [VALUE_WIDTH-1:0] row_entries[QDEPTH];
  int                            row_count   = 0;
  logic [CAP_WIDTH-1:0]          row_capacity = CAP_RESET;

  // Stall percentages for the sender and the receiver.
  int send_idle_pct = 36;
  int recv_idle_pct = 56;

  bit in_taken  = 1'b0;
  int err_count = 0;
  int cycles    = 0;

  // Capacities of the random phases; 31 exceeds the depth, 0 blocks inserts.
  int phase_caps[9] = '{16, 31, 3, 1, 17, 0, 8, 2, 16};

  sorted_array_priority_queue_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Applies one command to the scoreboard row and returns the result it
  // should produce.
  function automatic out_item_t apply_queue_op(input in_item_t op);
    out_item_t res;
    int        lim;
    int        slot;
    res.status       = ST_PUSHED;
    res.popped_value = '0;
    lim = (int'(row_capacity) < QDEPTH) ? int'(row_capacity) : QDEPTH;
    if (op.command == CMD_INSERT) begin
      if (row_count >= lim) begin
        res.status = ST_OVERFLOW;
      end else begin
        // The new value goes ahead of the first entry less than or equal to it.
        slot = row_count;
        for (int i = row_count - 1; i >= 0; i--) begin
          if ($signed(op.value) >= $signed(row_entries[i])) slot = i;
        end
        for (int i = row_count; i > slot; i--) row_entries[i] = row_entries[i-1];
        row_entries[slot] = op.value;
        row_count++;
      end
    end else begin
      if (row_count == 0) begin
        res.status = ST_UNDERFLOW;
      end else begin
        res.status       = ST_POPPED;
        res.popped_value = row_entries[0];
        for (int i = 1; i < row_count; i++) row_entries[i-1] = row_entries[i];
        row_count--;
      end
    end
    res.occupancy = row_count[OCC_WIDTH-1:0];
    return res;
  endfunction

  task automatic push_item(input logic cmd, input logic [VALUE_WIDTH-1:0] val);
    in_item_t it;
    it.command = cmd;
    it.value   = val;
    pending_items.push_back(it);
  endtask

  // Waits until every beat is sent and every result has come back.
  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_WIDTH-1:0] cap);
    @(negedge clk);
    cfg_we       <= 1'b1;
    cfg_data     <= cap;
    row_capacity  = cap;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Input driver: holds a beat until it is taken, then presents the next one
  // or idles.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    in_taken = 1'b0;
  end

  // Receiver back-pressure.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Monitor and scoreboard: checks result beats, then predicts accepted ones.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end else if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("unexpected result: status=%0d value=%0d occupancy=%0d",
                     out_data.status, out_data.popped_value, out_data.occupancy);
        end else begin
          out_item_t want;
          want = expected_results.pop_front();
          if (out_data.status !== want.status ||
              out_data.popped_value !== want.popped_value ||
              out_data.occupancy !== want.occupancy) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
              $display("mismatch: expected status=%0d value=%0d occupancy=%0d, got status=%0d value=%0d occupancy=%0d",
                       want.status, want.popped_value, want.occupancy,
                       out_data.status, out_data.popped_value, out_data.occupancy);
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_queue_op(in_data));
        in_taken = 1'b1;
      end
    end
  end

  // Stimulus sequence.
  initial begin
    int                      left;
    int                      run;
    int                      ins_pct;
    logic [VALUE_WIDTH-1:0]  val;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Reset capacity: empty delete, extreme and equal values, drain to empty.
    push_item(CMD_DELETE, 32'd0);
    push_item(CMD_INSERT, 32'h7FFF_FFFF);
    push_item(CMD_INSERT, 32'h8000_0000);
    push_item(CMD_INSERT, 32'h0000_0000);
    push_item(CMD_INSERT, 32'hFFFF_FFFF);
    push_item(CMD_INSERT, 32'h0000_0000);
    push_item(CMD_INSERT, 32'h0000_0001);
    repeat (6) push_item(CMD_DELETE, 32'hFFFF_FFFF);
    push_item(CMD_DELETE, 32'h5555_5555);
    wait_drained();

    // Capacity zero: inserts overflow, deletes still report underflow.
    write_capacity(5'd0);
    push_item(CMD_INSERT, 32'd5);
    push_item(CMD_DELETE, 32'd0);
    wait_drained();

    // Fill to a small capacity, then lower it below the occupancy.
    write_capacity(5'd2);
    push_item(CMD_INSERT, 32'd10);
    push_item(CMD_INSERT, 32'd10);
    push_item(CMD_INSERT, 32'd20);
    wait_drained();
    write_capacity(5'd1);
    push_item(CMD_INSERT, 32'd30);
    push_item(CMD_DELETE, 32'd0);
    push_item(CMD_INSERT, 32'd5);
    push_item(CMD_DELETE, 32'd0);
    push_item(CMD_DELETE, 32'd0);
    wait_drained();

    // Random phases: bursts lean toward inserts or deletes so the queue
    // swings between empty and full.
    for (int p = 0; p < 9; p++) begin
      case (p / 3)
        0:       begin send_idle_pct = 36; recv_idle_pct = 56; end
        1:       begin send_idle_pct = 56; recv_idle_pct = 36; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      write_capacity(phase_caps[p][CAP_WIDTH-1:0]);
      left = ITEMS_PER_PHASE;
      while (left > 0) begin
        run = $urandom_range(4, 24);
        case ($urandom_range(0, 2))
          0:       ins_pct = 15;
          1:       ins_pct = 50;
          default: ins_pct = 85;
        endcase
        for (int k = 0; k < run && left > 0; k++) begin
          // Small values give many ties; extremes and full-width values mix in.
          case ($urandom_range(0, 9))
            0:       val = 32'h7FFF_FFFF;
            1:       val = 32'h8000_0000;
            2, 3, 4: val = int'($urandom_range(0, 8)) - 4;
            default: val = $urandom();
          endcase
          push_item(($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_DELETE, val);
          left--;
        end
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (err_count == 0 && expected_results.size() == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
